// ----- design/assert_macros.svh -----
// Assertion macros shared by the selector RTL.
// No dependencies; simulation builds see the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("selector assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("selector forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- design/ers_pkg.sv -----
// Shared constants and item codes for the elite and roulette selector.
// No dependencies.
package ers_pkg;

	// item codes carried on the mode field
	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd2;

	// defaults for the top level parameters
	localparam int DEF_POP_SIZE     = 256;
	localparam int DEF_FITNESS_BITS = 9;
	localparam int DEF_RANDOM_BITS  = 16;

	// weight sum saturates at all ones of this width
	localparam int SUM_W = 17;
	localparam logic [SUM_W-1:0] SUM_LIMIT = '1;

	// reported indexes are the low bits of the position
	localparam int INDEX_W = 8;

endpackage

// ----- design/elite_and_roulette_selector_core.sv -----
// Elite and roulette selector: top level with the fitness memory and scan sequencer.
// Depends on ers_pkg and assert_macros.svh.
//
// Usage: send a clear item (mode 0), then one load item (mode 1) per individual,
// in order; each load stores the fitness in an internal
// memory while the running sum of fitness+1 (saturating at 2^17-1) and the
// elite position (highest fitness, later entry wins a tie) are updated.
// Loads beyond POP_SIZE entries are dropped, mode 3 is ignored. A draw item
// (mode 2) carries random_fraction r; the block forms
// arrow = ((r * sum) >> RANDOM_BITS) + 1 and walks the stored values from
// index 0, adding fitness+1, until the prefix sum reaches the arrow or the
// last loaded entry is hit. It returns one result item: elite_index,
// roulette_index and same_as_elite (set when both match; draw again).
// A draw on an empty population returns 0, 0, 1.
// Draw steps: the accept state, the multiply (S_ARROW), then the walk (S_SCAN)
// with one memory read per entry, up to the loaded count, through the single
// synchronous read port, and last the handoff to the output register (S_WAIT).
// A draw on an empty population skips the multiply and the walk. The handoff
// waits for as long as the output register still holds an unaccepted result.
// Clear and load items leave the block idle and ready for the next item.
// The output register holds a result while the next item is already taken.
// Input is accepted only while no draw is in flight, so loads never touch
// the memory during a scan.
`include "assert_macros.svh"

module elite_and_roulette_selector_core
	import ers_pkg::*;
#(
	parameter int POP_SIZE     = DEF_POP_SIZE,
	parameter int FITNESS_BITS = DEF_FITNESS_BITS,
	parameter int RANDOM_BITS  = DEF_RANDOM_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input item channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [MODE_W-1:0]        mode,
	input  logic [FITNESS_BITS-1:0]  fitness,
	input  logic [RANDOM_BITS-1:0]   random_fraction,
	// result item channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [INDEX_W-1:0]       elite_index,
	output logic [INDEX_W-1:0]       roulette_index,
	output logic                     same_as_elite
);

	localparam int AW       = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;  // memory address
	localparam int CW       = $clog2(POP_SIZE + 1);                 // loaded count
	localparam int PREFIX_W = FITNESS_BITS + CW;                    // full prefix sum
	localparam int CMP_W    = (PREFIX_W > SUM_W + 1) ? PREFIX_W : SUM_W + 1;
	localparam int PROD_W   = RANDOM_BITS + SUM_W;
	localparam int ACC_W    = ((SUM_W > FITNESS_BITS) ? SUM_W : FITNESS_BITS) + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ARROW,
		S_SCAN,
		S_WAIT
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           loaded_count_q;
	logic [SUM_W-1:0]        weight_sum_q;
	logic [FITNESS_BITS-1:0] best_value_q;
	logic [INDEX_W-1:0]      best_position_q;
	logic                    out_valid_q;
	logic [INDEX_W-1:0]      elite_index_q;
	logic [INDEX_W-1:0]      roulette_index_q;
	logic                    same_q;

	// draw datapath
	logic [RANDOM_BITS-1:0]  random_q;
	logic [CMP_W-1:0]        arrow_q;
	logic [CMP_W-1:0]        prefix_q;
	logic [AW-1:0]           scan_idx_q;
	logic [INDEX_W-1:0]      pick_q;

	// fitness memory, one synchronous read port
	logic [FITNESS_BITS-1:0] fit_mem [POP_SIZE];
	logic [FITNESS_BITS-1:0] mem_rdata_s1;
	logic [AW-1:0]           rd_addr;
	logic                    mem_we;

	logic                    in_fire;
	logic                    can_load;
	logic [ACC_W-1:0]        sum_next;
	logic [PROD_W-1:0]       product;
	logic [CMP_W-1:0]        prefix_next;
	logic                    scan_last;
	logic                    scan_hit;
	logic                    out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign can_load  = (loaded_count_q < CW'(POP_SIZE));
	assign mem_we    = in_fire && (mode == MODE_LOAD) && can_load;
	assign out_free  = !out_valid_q || out_ready;

	assign sum_next  = ACC_W'(weight_sum_q) + ACC_W'(fitness) + ACC_W'(1);
	assign product   = PROD_W'(random_q) * PROD_W'(weight_sum_q);

	// entry scan_idx_q sits in mem_rdata_s1 during S_SCAN; next address is prefetched
	assign rd_addr     = (state_q == S_SCAN) ? scan_idx_q + AW'(1) : '0;
	assign prefix_next = prefix_q + CMP_W'(mem_rdata_s1) + CMP_W'(1);
	assign scan_hit    = (prefix_next >= arrow_q);
	assign scan_last   = ((CW'(scan_idx_q) + CW'(1)) == loaded_count_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fit_mem[loaded_count_q[AW-1:0]] <= fitness;
		end
		mem_rdata_s1 <= fit_mem[rd_addr];
	end

	// draw datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire && (mode == MODE_DRAW)) begin
			random_q <= random_fraction;
			pick_q   <= '0;
		end
		if (state_q == S_ARROW) begin
			arrow_q    <= CMP_W'(product[PROD_W-1:RANDOM_BITS]) + CMP_W'(1);
			prefix_q   <= '0;
			scan_idx_q <= '0;
		end
		if (state_q == S_SCAN) begin
			prefix_q <= prefix_next;
			if (scan_hit || scan_last) begin
				pick_q <= INDEX_W'(scan_idx_q);
			end else begin
				scan_idx_q <= scan_idx_q + AW'(1);
			end
		end
	end

	// control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			loaded_count_q   <= '0;
			weight_sum_q     <= '0;
			best_value_q     <= '0;
			best_position_q  <= '0;
			out_valid_q      <= 1'b0;
			elite_index_q    <= '0;
			roulette_index_q <= '0;
			same_q           <= 1'b0;
		end else begin
			// in S_WAIT the handoff below owns out_valid_q
			if (out_valid_q && out_ready && (state_q != S_WAIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (mode)
							MODE_CLEAR: begin
								loaded_count_q  <= '0;
								weight_sum_q    <= '0;
								best_value_q    <= '0;
								best_position_q <= '0;
							end
							MODE_LOAD: begin
								if (can_load) begin
									if (fitness >= best_value_q) begin
										best_value_q    <= fitness;
										best_position_q <= INDEX_W'(loaded_count_q);
									end
									weight_sum_q <= (sum_next > ACC_W'(SUM_LIMIT)) ?
										SUM_LIMIT : SUM_W'(sum_next);
									loaded_count_q <= loaded_count_q + CW'(1);
								end
							end
							MODE_DRAW: begin
								// empty population skips the walk: pick stays 0
								state_q <= (loaded_count_q == '0) ? S_WAIT : S_ARROW;
							end
							default: begin
							end
						endcase
					end
				end
				S_ARROW: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_hit || scan_last) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						elite_index_q    <= best_position_q;
						roulette_index_q <= pick_q;
						same_q           <= (pick_q == best_position_q);
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign elite_index    = elite_index_q;
	assign roulette_index = roulette_index_q;
	assign same_as_elite  = same_q;

	`ASSERT_CLK(a_same_flag, clk, arst_n, out_valid |-> (same_as_elite == (roulette_index == elite_index)))
	`ASSERT_CLK(a_scan_in_range, clk, arst_n, (state_q == S_SCAN) |-> (CW'(scan_idx_q) < loaded_count_q))
	`ASSERT_NEVER(a_count_bound, clk, arst_n, loaded_count_q > CW'(POP_SIZE))

endmodule

// ----- tb/sv/tb_elite_and_roulette_selector_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for elite_and_roulette_selector_core: directed and random
// clear/load/draw streams, each draw result checked against a behavioral selector.
// Depends on ers_pkg and the selector RTL.
module tb_elite_and_roulette_selector_core;
	import ers_pkg::*;

	localparam int POP_SIZE     = DEF_POP_SIZE;
	localparam int FITNESS_BITS = DEF_FITNESS_BITS;
	localparam int RANDOM_BITS  = DEF_RANDOM_BITS;

	// mode 3 has no meaning; the block must drop it
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// covers a full draw, which walks POP_SIZE entries, with margin for its overhead
	localparam int DRAIN_CYCLES = POP_SIZE + 16;
	// long output hold-off used to back the block up into its input
	localparam int HOLD_CYCLES  = 400;
	// cycles with no item moving on either side before giving up
	localparam int STALL_LIMIT  = 4000;

	typedef struct packed {
		logic [INDEX_W-1:0] elite;
		logic [INDEX_W-1:0] roulette;
		logic               same;
	} selection_t;

	logic                    clk             = 1'b0;
	logic                    arst_n          = 1'b0;
	logic                    in_valid        = 1'b0;
	logic                    in_ready;
	logic [MODE_W-1:0]       mode            = MODE_CLEAR;
	logic [FITNESS_BITS-1:0] fitness         = '0;
	logic [RANDOM_BITS-1:0]  random_fraction = '0;
	logic                    out_valid;
	logic                    out_ready       = 1'b0;
	logic [INDEX_W-1:0]      elite_index;
	logic [INDEX_W-1:0]      roulette_index;
	logic                    same_as_elite;

	// selector model state, starts in its reset state
	logic [FITNESS_BITS-1:0] pop_fitness [POP_SIZE];
	int unsigned             pop_count    = 0;
	logic [SUM_W-1:0]        weight_total = '0;
	logic [FITNESS_BITS-1:0] top_fitness  = '0;
	logic [INDEX_W-1:0]      top_position = '0;

	// selections still owed by the block, oldest first
	selection_t pending_selections[$];

	int error_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;
	bit hold_request   = 1'b0;

	always #5 clk = ~clk;

	elite_and_roulette_selector_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.fitness        (fitness),
		.random_fraction(random_fraction),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.elite_index    (elite_index),
		.roulette_index (roulette_index),
		.same_as_elite  (same_as_elite)
	);

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// Roulette pick: arrow = ((r * sum) >> RANDOM_BITS) + 1, first prefix
	// of fitness+1 that reaches it. Saturated sums still scan full prefixes.
	function automatic selection_t draw_selection(input logic [RANDOM_BITS-1:0] r);
		selection_t        pick;
		longint unsigned   arrow;
		longint unsigned   prefix;
		longint unsigned   r_wide;
		longint unsigned   sum_wide;
		logic [INDEX_W-1:0] pos;
		if (pop_count == 0) begin
			pick.elite    = '0;
			pick.roulette = '0;
			pick.same     = 1'b1;
			return pick;
		end
		r_wide   = r;
		sum_wide = weight_total;
		arrow    = ((r_wide * sum_wide) >> RANDOM_BITS) + 1;
		prefix   = 0;
		pos      = '0;
		for (int unsigned i = 0; i < pop_count; i++) begin
			prefix += longint'(pop_fitness[i]) + 1;
			pos = INDEX_W'(i);
			if (prefix >= arrow)
				break;
		end
		pick.elite    = top_position;
		pick.roulette = pos;
		pick.same     = (pos == top_position);
		return pick;
	endfunction

	task automatic predict_item(input logic [MODE_W-1:0] m, input logic [FITNESS_BITS-1:0] f,
			input logic [RANDOM_BITS-1:0] r);
		int unsigned grown;
		case (m)
		MODE_CLEAR: begin
			pop_count    = 0;
			weight_total = '0;
			top_fitness  = '0;
			top_position = '0;
		end
		MODE_LOAD: begin
			// loads into a full population are dropped
			if (pop_count < POP_SIZE) begin
				pop_fitness[pop_count] = f;
				if (f >= top_fitness) begin
					top_fitness  = f;
					top_position = INDEX_W'(pop_count);
				end
				grown        = weight_total + f + 1;
				weight_total = (grown > SUM_LIMIT) ? SUM_LIMIT : SUM_W'(grown);
				pop_count++;
			end
		end
		MODE_DRAW: begin
			pending_selections.push_back(draw_selection(r));
		end
		default: ;
		endcase
	endtask

	// Offer one item at the falling edge, with random idle cycles first,
	// and hold it until the block takes it.
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [FITNESS_BITS-1:0] f,
			input logic [RANDOM_BITS-1:0] r);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		mode            <= m;
		fitness         <= f;
		random_fraction <= r;
		do
			@(posedge clk);
		while (!in_ready);
		predict_item(m, f, r);
	endtask

	function automatic logic [FITNESS_BITS-1:0] random_fitness(input int style);
		case (style)
		0: return FITNESS_BITS'($urandom_range(0, 256));
		1: return FITNESS_BITS'($urandom_range(0, 3));   // lots of ties
		2: return FITNESS_BITS'($urandom_range(0, 2**FITNESS_BITS - 1));
		default: return ($urandom_range(7) == 0) ? FITNESS_BITS'($urandom_range(200, 511)) : '0;
		endcase
	endfunction

	function automatic logic [RANDOM_BITS-1:0] pick_fraction();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return RANDOM_BITS'($urandom_range(0, 2**RANDOM_BITS - 1));
	endfunction

	// Output side: random stalls, or a long counted hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) begin
					out_ready <= 1'b0;
					@(negedge clk);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Result checker: every accepted result against the oldest expectation.
	always @(posedge clk) begin : check_results
		selection_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_selections.size() == 0) begin
				report_error($sformatf("result with no draw pending: elite %0d roulette %0d",
					elite_index, roulette_index));
			end else begin
				want = pending_selections.pop_front();
				if (elite_index !== want.elite)
					report_error($sformatf("elite_index expected %0d got %0d",
						want.elite, elite_index));
				if (roulette_index !== want.roulette)
					report_error($sformatf("roulette_index expected %0d got %0d",
						want.roulette, roulette_index));
				if (same_as_elite !== want.same)
					report_error($sformatf("same_as_elite expected %0d got %0d",
						want.same, same_as_elite));
			end
		end
	end

	// Watchdog: no item moving on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// Empty draws, field extremes, ties, unused mode, single-entry population.
	task automatic test_directed();
		send_item(MODE_CLEAR, '0, '0);
		send_item(MODE_DRAW, '0, '1);        // empty population
		send_item(MODE_UNUSED, '1, '1);
		send_item(MODE_LOAD, '0, '1);
		send_item(MODE_LOAD, '1, '0);
		send_item(MODE_LOAD, 9'd256, '0);
		send_item(MODE_LOAD, '1, '0);        // tie with the max, later wins
		send_item(MODE_LOAD, '0, '0);
		send_item(MODE_DRAW, '1, '0);
		send_item(MODE_DRAW, '0, '1);
		send_item(MODE_DRAW, '0, 16'h8000);
		send_item(MODE_DRAW, '0, 16'h0001);
		send_item(MODE_UNUSED, '0, '0);
		send_item(MODE_DRAW, '0, 16'h4000);
		send_item(MODE_CLEAR, '1, '1);
		send_item(MODE_DRAW, '0, 16'h1234);  // empty again after clear
		send_item(MODE_LOAD, '0, '0);
		send_item(MODE_DRAW, '0, '1);        // one entry: roulette equals elite
		send_item(MODE_LOAD, '0, '0);        // tie at zero moves the elite
		send_item(MODE_DRAW, '0, '0);
		send_item(MODE_DRAW, '0, '1);
	endtask

	// Full populations: saturated sum, loads past the end, full-length scans.
	task automatic test_full_population();
		send_item(MODE_CLEAR, '0, '0);
		repeat (POP_SIZE + 2)
			send_item(MODE_LOAD, '1, pick_fraction());
		send_item(MODE_DRAW, '0, '1);
		send_item(MODE_DRAW, '0, '0);
		repeat (3)
			send_item(MODE_DRAW, '0, pick_fraction());
		send_item(MODE_CLEAR, '0, '0);
		repeat (POP_SIZE + 1)
			send_item(MODE_LOAD, random_fitness(0), '0);
		repeat (4)
			send_item(MODE_DRAW, random_fitness(2), pick_fraction());
	endtask

	// Output held off while draws keep coming, so the input side stalls.
	task automatic test_backpressure();
		send_item(MODE_CLEAR, '0, '0);
		repeat (10)
			send_item(MODE_LOAD, random_fitness(0), '0);
		hold_request = 1'b1;
		repeat (15)
			send_item(MODE_DRAW, '0, pick_fraction());
	endtask

	// Populations with random content: mostly small, a few near full size,
	// with stray unused modes, early draws and the odd mid-load clear.
	task automatic test_random(input int item_goal);
		int sent;
		int pop_target;
		int loaded;
		int style;
		int roll;
		sent = 0;
		while (sent < item_goal) begin
			send_item(MODE_CLEAR, random_fitness(2), pick_fraction());
			sent++;
			loaded = 0;
			style  = $urandom_range(3);
			if ($urandom_range(19) == 0)
				pop_target = $urandom_range(POP_SIZE - 40, POP_SIZE + 4);
			else
				pop_target = $urandom_range(1, 20);
			if ($urandom_range(9) == 0) begin
				send_item(MODE_DRAW, random_fitness(2), pick_fraction());
				sent++;
			end
			while (loaded < pop_target) begin
				roll = $urandom_range(199);
				if (roll == 0) begin
					send_item(MODE_CLEAR, random_fitness(2), pick_fraction());
					loaded = 0;
					sent++;
				end else if (roll < 8) begin
					send_item(MODE_UNUSED, random_fitness(2), pick_fraction());
				end else if (roll < 24) begin
					send_item(MODE_DRAW, random_fitness(2), pick_fraction());
					sent++;
				end else begin
					send_item(MODE_LOAD, random_fitness(style), pick_fraction());
					if (loaded < POP_SIZE)
						sent++;
					loaded++;
				end
			end
			repeat ($urandom_range(1, 6)) begin
				send_item(MODE_DRAW, random_fitness(2), pick_fraction());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (4)
			@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_population();
		test_backpressure();

		send_idle_pct  = 16;
		recv_stall_pct = 64;
		test_random(340);
		send_idle_pct  = 64;
		recv_stall_pct = 16;
		test_random(340);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random(340);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_selections.size() != 0)
			@(posedge clk);
		// let any late stray result show up
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- elite_and_roulette_selector_core.f -----
+incdir+design
design/ers_pkg.sv
design/elite_and_roulette_selector_core.sv
tb/sv/tb_elite_and_roulette_selector_core.sv
